// ----- hw/rtl/lpr_pkg.sv -----
// ============================================================================
// lpr_pkg - shared types and constants of the IPv4 route table
// Request and response payloads, the stored route entry, operation and
// status codes, and the prefix match function.
// ============================================================================
`default_nettype none

package lpr_pkg;

    localparam int MAX_ROUTES_DEF = 16;
    localparam int OCTET_W        = 8;
    localparam int OCTETS         = 4;
    localparam int ADDR_W         = OCTET_W * OCTETS;
    localparam int PLEN_W         = 6;

    localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(ADDR_W);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_length;
        logic [ADDR_W-1:0] next_hop;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [PLEN_W-1:0] matched_prefix;
        logic [ADDR_W-1:0] via_address;
        logic              status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [PLEN_W-1:0] length;
        logic [ADDR_W-1:0] gateway;
    } route_t;

    // Whole prefix octets compare exactly; the partial octet compares the
    // masked address octet against the stored octet as it stands.
    function automatic logic prefix_match(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] net,
        input logic [PLEN_W-1:0] len
    );
        logic [2:0]         whole;
        logic [2:0]         rest;
        logic [OCTET_W-1:0] mask;
        logic [OCTET_W-1:0] a_oct;
        logic [OCTET_W-1:0] n_oct;
        logic               ok;
        whole = len[5:3];
        rest  = len[2:0];
        mask  = ~(8'hFF >> rest);
        ok    = 1'b1;
        for (int i = 0; i < OCTETS; i++) begin
            a_oct = addr[ADDR_W-1-OCTET_W*i -: OCTET_W];
            n_oct = net[ADDR_W-1-OCTET_W*i -: OCTET_W];
            if (3'(i) < whole) begin
                if (a_oct != n_oct)
                    ok = 1'b0;
            end
            else if (3'(i) == whole && rest != 3'd0) begin
                if ((a_oct & mask) != n_oct)
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lpr_req_if.sv -----
// ============================================================================
// lpr_req_if - request channel of the route table
// Valid/ready handshake carrying one lookup or insert request.
// ============================================================================
`default_nettype none

interface lpr_req_if
    import lpr_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lpr_rsp_if.sv -----
// ============================================================================
// lpr_rsp_if - response channel of the route table
// Valid/ready handshake carrying one lookup or insert response.
// ============================================================================
`default_nettype none

interface lpr_rsp_if
    import lpr_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ipv4_longest_prefix_route_table_core.sv -----
// ============================================================================
// ipv4_longest_prefix_route_table_core - IPv4 longest prefix route table
// Sorted route memory with a sequencer that scans for lookups and shifts
// entries for inserts, one memory access at a time.
// ============================================================================
// Routes live in a memory of MAX_ROUTES entries with one write port and one
// registered read port, kept sorted by prefix length, longest first; among
// equal lengths the newest route comes first. A lookup request walks the
// table from entry 0 and answers with the first matching route (hit, its
// prefix length and gateway), or a miss with zeros. An insert request walks
// from the last entry backward, moving each route whose prefix is not longer
// than the new one up by one slot, then writes the new route into the gap;
// when the table is full the route is dropped and status is set. Each
// visited entry passes a read state for the registered memory read and then
// a compare state (which also makes the shift write). A lookup examines
// entries until the first match or the last route. An insert examines the
// routes moved plus the one the walk stops at, with one more put state when
// the new route lands in entry 0, either on an empty table or after every
// route has moved; a dropped insert goes straight to the done state.
// Entries are visited one at a time through the memory's single read port.
// The block takes one request at a time; a finished response sits in an
// output register so the next request is taken while it waits. Prefix
// lengths above 32 are stored as 32. Never-written entries are never used:
// the route count bounds every walk.
// ============================================================================
`default_nettype none

module ipv4_longest_prefix_route_table_core
    import lpr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpr_req_if.sink    req,
    lpr_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(MAX_ROUTES);
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ROUTES);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LREAD = 3'd1;
    localparam logic [2:0] ST_LCMP  = 3'd2;
    localparam logic [2:0] ST_IREAD = 3'd3;
    localparam logic [2:0] ST_ICMP  = 3'd4;
    localparam logic [2:0] ST_IPUT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Route memory and its registered read data
    route_t             route_mem [MAX_ROUTES];
    route_t             rd_reg;

    logic [2:0]         state_reg,     state_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [ADDR_W-1:0]  addr_reg,      addr_next;
    logic [PLEN_W-1:0]  plen_reg,      plen_next;
    logic [ADDR_W-1:0]  hop_reg,       hop_next;
    rsp_t               pend_reg,      pend_next;
    rsp_t               out_reg,       out_next;
    logic               out_valid_reg, out_valid_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    route_t             wr_data;
    route_t             new_route;
    logic               accept;
    logic               last_entry;
    logic [PLEN_W-1:0]  req_plen_sat;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign req_plen_sat = (req.data.prefix_length > MAX_PREFIX) ? MAX_PREFIX
                                                                 : req.data.prefix_length;

    assign new_route.network = addr_reg;
    assign new_route.length  = plen_reg;
    assign new_route.gateway = hop_reg;

    // Current scan index is the last stored route
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        plen_next      = plen_reg;
        hop_next       = hop_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = new_route;

        // Drain the output register when the consumer takes the response
        if (rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = req.data.address;
                    plen_next = req_plen_sat;
                    hop_next  = req.data.next_hop;
                    pend_next = '0;
                    if (req.data.op == OP_LOOKUP)
                    begin
                        idx_next = '0;
                        if (count_reg == '0)
                            state_next = ST_DONE;
                        else
                            state_next = ST_LREAD;
                    end
                    else
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            pend_next.status = STATUS_FULL;
                            state_next       = ST_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = ST_IPUT;
                        end
                        else
                        begin
                            idx_next   = IDX_W'(count_reg - CNT_W'(1));
                            state_next = ST_IREAD;
                        end
                    end
                end
            end

            ST_LREAD:
            begin
                state_next = ST_LCMP;
            end

            ST_LCMP:
            begin
                if (prefix_match(addr_reg, rd_reg.network, rd_reg.length))
                begin
                    pend_next.hit            = 1'b1;
                    pend_next.matched_prefix = rd_reg.length;
                    pend_next.via_address    = rd_reg.gateway;
                    state_next               = ST_DONE;
                end
                else if (last_entry)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_LREAD;
                end
            end

            ST_IREAD:
            begin
                state_next = ST_ICMP;
            end

            ST_ICMP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                if (plen_reg >= rd_reg.length)
                begin
                    // Move this route up one slot; walk down, or after entry 0 put the new route there
                    wr_data = rd_reg;
                    if (idx_reg == '0)
                        state_next = ST_IPUT;
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_IREAD;
                    end
                end
                else
                begin
                    // Drop the new route into the gap above this one
                    wr_data    = new_route;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_IPUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_route;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Route memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            route_mem[wr_addr] <= wr_data;
        rd_reg <= route_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        plen_reg <= plen_next;
        hop_reg  <= hop_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
